>>> rtl/signed_int_to_decimal_ascii_core_defines.svh
// Assertion macros for the checker file of the decimal ASCII core.
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_CORE_DEFINES_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define SITDA_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sitda check failed");

// Next-cycle implication, disabled while reset is high.
`define SITDA_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sitda check failed");

`endif

>>> rtl/sitda_pkg.sv
// Package: shared constants and helpers of the decimal ASCII core.
`timescale 1ns / 1ps
package sitda_pkg;

  localparam int DEFAULT_VALUE_BITS = 32;
  localparam int QUEUE_DEPTH        = 2;
  localparam int CHAR_W             = 6;
  localparam int OUT_DATA_W         = 8;

  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 6'd48;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 6'd45;
  localparam logic [CHAR_W-1:0] CHAR_NINE  = 6'd57;

  // Decimal digits enough for any magnitude of the given bit count
  // (302/1000 slightly above log10(2), so never short).
  function automatic int digit_count(input int bits);
    return (bits * 302) / 1000 + 1;
  endfunction

  // Input tdata width: value bits rounded up to whole bytes.
  function automatic int in_data_width(input int bits);
    return ((bits + 7) / 8) * 8;
  endfunction

endpackage

>>> rtl/signed_int_to_decimal_ascii_core.sv
// Top level: signed integer to decimal ASCII character stream.
//
//   channel | dir | payload                              | handshake
//   --------+-----+--------------------------------------+------------------
//   s_*     | in  | tdata: value (two's complement)      | tvalid / tready
//   m_*     | out | tdata: char_code, 2 zero pad; tlast   | tvalid / tready
//
// Per value: a one-bit-per-cycle double-dabble shift over VALUE_BITS bits, then
// N characters, N being its character count (1..11 at 32 bits).
// Input transactions go on into the two-entry queue while a conversion runs.
// Reset: synchronous, active high; clears the queue, the converter state and
// the output valid. Output stalls hold the character in the output register.
`timescale 1ns / 1ps
module signed_int_to_decimal_ascii_core
  import sitda_pkg::*;
#(
  parameter int VALUE_BITS = DEFAULT_VALUE_BITS
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [in_data_width(VALUE_BITS)-1:0] s_tdata,   // [VALUE_BITS-1:0] value
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [OUT_DATA_W-1:0]               m_tdata,   // [5:0] char_code, [7:6] zero
  output logic                                m_tlast    // last_char
);

  localparam int IN_W = in_data_width(VALUE_BITS);

  // Front to queue: sign bit on top of the magnitude.
  logic                q_push;
  logic [VALUE_BITS:0] q_push_data;
  logic                q_full;
  // Queue to back end.
  logic                q_pop;
  logic                q_valid;
  logic [VALUE_BITS:0] q_head;
  logic [CHAR_W-1:0]   char_code;

  // Classify: take the sign, form the unsigned magnitude.
  sitda_front #(
    .VALUE_BITS (VALUE_BITS),
    .IN_W       (IN_W)
  ) u_front (
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_data   (q_push_data)
  );

  // Decouple: lets the input side run ahead of a long conversion.
  sitda_queue #(
    .ENTRY_W (VALUE_BITS + 1)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_data  (q_push_data),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_data  (q_head)
  );

  // Convert and emit: one character per output transaction.
  sitda_back #(
    .VALUE_BITS (VALUE_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_data    (q_head),
    .q_pop     (q_pop),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .char_code (char_code),
    .last_char (m_tlast)
  );

  // Pad the 6-bit code to a whole byte.
  assign m_tdata = {(OUT_DATA_W - CHAR_W)'(0), char_code};

endmodule

>>> rtl/sitda_queue.sv
// Short register queue between the classifying front and the converting back.
`timescale 1ns / 1ps
module sitda_queue
  import sitda_pkg::*;
#(
  parameter int ENTRY_W = DEFAULT_VALUE_BITS + 1
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  logic [ENTRY_W-1:0] push_data,
  output logic               full,
  input  logic               pop,
  output logic               head_valid,
  output logic [ENTRY_W-1:0] head_data
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [ENTRY_W-1:0] mem [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;

  assign full       = (count == CNT_W'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head_data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

>>> rtl/sitda_front.sv
// Front end: accept a value, split it into sign and unsigned magnitude.
`timescale 1ns / 1ps
module sitda_front
  import sitda_pkg::*;
#(
  parameter int VALUE_BITS = DEFAULT_VALUE_BITS,
  parameter int IN_W       = in_data_width(DEFAULT_VALUE_BITS)
) (
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_W-1:0]       s_tdata,
  input  logic                  q_full,
  output logic                  q_push,
  output logic [VALUE_BITS:0]   q_data
);

  logic [VALUE_BITS-1:0] raw;
  logic                  negative;
  logic [VALUE_BITS-1:0] mag;

  // Bits above the value width are ignored; the top kept bit is the sign.
  assign raw      = s_tdata[VALUE_BITS-1:0];
  assign negative = raw[VALUE_BITS-1];
  // Two's complement negate; the most negative value comes out as its
  // unsigned magnitude.
  assign mag      = negative ? (~raw + 1'b1) : raw;

  assign s_tready = !q_full;
  assign q_push   = s_tvalid && !q_full;
  assign q_data   = {negative, mag};

endmodule

>>> rtl/sitda_back.sv
// Back end: serial double-dabble conversion and character emission.
`timescale 1ns / 1ps
module sitda_back
  import sitda_pkg::*;
#(
  parameter int VALUE_BITS = DEFAULT_VALUE_BITS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  q_valid,
  input  logic [VALUE_BITS:0]   q_data,
  output logic                  q_pop,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [CHAR_W-1:0]     char_code,
  output logic                  last_char
);

  localparam int NDIG  = digit_count(VALUE_BITS);
  localparam int BCD_W = 4 * NDIG;
  localparam int IDX_W = (NDIG > 1) ? $clog2(NDIG) : 1;
  localparam int CNT_W = $clog2(VALUE_BITS);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CONV = 2'd1;
  localparam logic [1:0] ST_FIND = 2'd2;
  localparam logic [1:0] ST_EMIT = 2'd3;

  logic [1:0]            state;
  logic [CNT_W-1:0]      cnt;
  logic [VALUE_BITS-1:0] shift;
  logic [BCD_W-1:0]      bcd;
  logic [BCD_W-1:0]      bcd_adj;
  logic                  neg_pend;
  logic [IDX_W-1:0]      idx;
  logic [IDX_W-1:0]      lead;
  logic [3:0]            cur_digit;
  logic                  out_free;

  assign q_pop    = (state == ST_IDLE) && q_valid;
  assign out_free = !m_tvalid || m_tready;

  // Add 3 to every BCD digit of 5 or more before the shift.
  always_comb begin
    for (int i = 0; i < NDIG; i++) begin
      bcd_adj[4*i +: 4] = (bcd[4*i +: 4] >= 4'd5) ? bcd[4*i +: 4] + 4'd3 : bcd[4*i +: 4];
    end
  end

  // Highest nonzero digit; zero keeps the lowest digit.
  always_comb begin
    lead = '0;
    for (int i = 0; i < NDIG; i++) begin
      if (bcd[4*i +: 4] != 4'd0) begin
        lead = IDX_W'(i);
      end
    end
  end

  assign cur_digit = bcd[4*idx +: 4];

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (q_valid) begin
            shift    <= q_data[VALUE_BITS-1:0];
            neg_pend <= q_data[VALUE_BITS];
            bcd      <= '0;
            cnt      <= CNT_W'(VALUE_BITS - 1);
            state    <= ST_CONV;
          end
        end
        ST_CONV: begin
          {bcd, shift} <= {bcd_adj[BCD_W-2:0], shift, 1'b0};
          if (cnt == '0) begin
            state <= ST_FIND;
          end else begin
            cnt <= cnt - 1'b1;
          end
        end
        ST_FIND: begin
          idx   <= lead;
          state <= ST_EMIT;
        end
        ST_EMIT: begin
          if (out_free) begin
            if (neg_pend) begin
              char_code <= CHAR_MINUS;
              last_char <= 1'b0;
              neg_pend  <= 1'b0;
            end else begin
              char_code <= CHAR_ZERO + {2'b00, cur_digit};
              last_char <= (idx == '0);
              if (idx == '0) begin
                state <= ST_IDLE;
              end else begin
                idx <= idx - 1'b1;
              end
            end
          end
        end
        default: state <= ST_IDLE;
      endcase

      if (state == ST_EMIT && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule

>>> rtl/sitda_checker.sv
// Port checker for the decimal ASCII core, bound to the top level.
`timescale 1ns / 1ps
`include "signed_int_to_decimal_ascii_core_defines.svh"
module sitda_checker
  import sitda_pkg::*;
#(
  parameter int VALUE_BITS = DEFAULT_VALUE_BITS
) (
  input logic                                 clk,
  input logic                                 rst,
  input logic                                 s_tvalid,
  input logic                                 s_tready,
  input logic [in_data_width(VALUE_BITS)-1:0] s_tdata,
  input logic                                 m_tvalid,
  input logic                                 m_tready,
  input logic [OUT_DATA_W-1:0]                m_tdata,
  input logic                                 m_tlast
);

  // Hold a stalled character.
  `SITDA_ASSERT_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast))

  // Only a minus sign or a decimal digit, padding bits zero.
  `SITDA_ASSERT_NOW(a_char_legal, clk, rst, m_tvalid, (m_tdata[OUT_DATA_W-1:CHAR_W] == '0) && ((m_tdata[CHAR_W-1:0] == CHAR_MINUS) || ((m_tdata[CHAR_W-1:0] >= CHAR_ZERO) && (m_tdata[CHAR_W-1:0] <= CHAR_NINE))))

  // A minus sign is never marked last, so digits must follow it.
  `SITDA_ASSERT_NOW(a_minus_not_last, clk, rst, m_tvalid && (m_tdata[CHAR_W-1:0] == CHAR_MINUS), !m_tlast)

endmodule

bind signed_int_to_decimal_ascii_core sitda_checker #(
  .VALUE_BITS (VALUE_BITS)
) u_sitda_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);
